@@ rtl/rwsd_pkg.sv @@
// shared constants for the rolling window standard deviation block
`timescale 1ns / 1ps

package rwsd_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int CFG_W = 9;
	localparam int VOL_W = 23;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(20);
	localparam logic [VOL_W-1:0] VOL_MAX      = {VOL_W{1'b1}};

endpackage

@@ rtl/rwsd_in_if.sv @@
// input channel: one sample beat with its restart flag
`timescale 1ns / 1ps

interface rwsd_in_if #(
	parameter int SAMPLE_BITS = rwsd_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          restart;

	modport source (output valid, sample, restart, input ready);
	modport sink (input valid, sample, restart, output ready);
endinterface

@@ rtl/rwsd_out_if.sv @@
// output channel: one deviation beat with its window full flag
`timescale 1ns / 1ps

interface rwsd_out_if ();
	logic                           valid;
	logic                           ready;
	logic [rwsd_pkg::VOL_W-1:0]     volatility;
	logic                           window_full;

	modport source (output valid, volatility, window_full, input ready);
	modport sink (input valid, volatility, window_full, output ready);
endinterface

@@ rtl/rwsd_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module rwsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rwsd_mul.sv @@
// bit serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module rwsd_mul #(
	parameter int A_W = 8,
	parameter int B_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] p
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic [A_W+B_W-1:0] p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [A_W:0]       sum;

	// add into the upper half, then shift the whole product right
	assign sum = {1'b0, p_q[A_W+B_W-1 -: A_W]} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(B_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q >> 1;
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign p    = p_q;

endmodule

@@ rtl/rwsd_sqrt.sv @@
// bit serial integer square root, one root bit per cycle
`timescale 1ns / 1ps

module rwsd_sqrt #(
	parameter int R_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*R_W-1:0] x,
	output logic             busy,
	output logic [R_W-1:0]   root
);

	localparam int CNT_W = $clog2(R_W + 1);

	logic [2*R_W-1:0] x_q;
	logic [R_W:0]     rem_q;
	logic [R_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [R_W+2:0]   rem_sh;
	logic [R_W+2:0]   trial;
	logic             take;

	// bring down the next two radicand bits and try 4*root+1
	assign rem_sh = {rem_q, x_q[2*R_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(R_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[2*R_W-3:0], 2'b00};
			rem_q  <= take ? (R_W+1)'(rem_sh - trial) : rem_sh[R_W:0];
			root_q <= {root_q[R_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

@@ rtl/rwsd_div.sv @@
// bit serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rwsd_div #(
	parameter int N_W = 16,
	parameter int D_W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] n,
	input  logic [D_W-1:0] d,
	output logic           busy,
	output logic [N_W-1:0] q
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   q_q;
	logic [D_W-1:0]   d_q;
	logic [D_W-1:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     rem_sh;
	logic             take;

	// dividend bits leave the top of q_q as quotient bits enter below
	assign rem_sh = {rem_q, q_q[N_W-1]};
	assign take   = (rem_sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? D_W'(rem_sh - {1'b0, d_q}) : rem_sh[D_W-1:0];
			q_q   <= {q_q[N_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign q    = q_q;

endmodule

@@ rtl/rolling_window_std_deviation.sv @@
// top level: rolling window population standard deviation
//
//   channel   dir   handshake       payload
//   feed      in    valid / ready   sample, restart
//   result    out   valid / ready   volatility, window_full
//   cfg       in    cfg_we          cfg_wdata (window length)
//
// a beat that fills the window runs the squaring multipliers and then the
// three serial units (sum-squared multiplier, square root, divider), which
// run one bit per cycle each; a beat that leaves the window short ends
// after the squaring multipliers and the accumulate step.
// feed is taken only between beats; a finished result waits in the output
// register so the next sample can be taken while result is stalled.
// reset clears the window length to 20 and the history; no clearing pass.
`timescale 1ns / 1ps

module rolling_window_std_deviation #(
	parameter int MAX_WINDOW  = rwsd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = rwsd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rwsd_in_if.sink                     feed,
	rwsd_out_if.source                  result,
	input  logic                        cfg_we,
	input  logic [rwsd_pkg::CFG_W-1:0]  cfg_wdata
);

	localparam int SB     = SAMPLE_BITS;
	localparam int CW     = $clog2(MAX_WINDOW + 1);
	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int SUM_W  = SB + CW;
	localparam int ROOT_W = SB - 1 + CW;
	localparam int SQ_W   = 2 * SB - 2 + CW;
	localparam int NUM_W  = 2 * ROOT_W;
	localparam int DIF_W  = CW + 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOAD = 8'b0000_0010,
		S_SQ   = 8'b0000_0100,
		S_ACC  = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_ROOT = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [rwsd_pkg::CFG_W-1:0]      win_len_q;
	logic [AW-1:0]                   slot_q;
	logic [CW-1:0]                   filled_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic [SQ_W-1:0]                 sq_sum_q;
	logic                            evict_q;
	logic                            full_q;
	logic                            out_valid_q;
	logic signed [SB-1:0]            sample_q;
	logic signed [SB-1:0]            old_q;
	logic [rwsd_pkg::VOL_W-1:0]      vol_q;
	logic                            wfull_q;

	logic [CW-1:0]                   w;
	logic [DIF_W-1:0]                slot_dif;
	logic [AW-1:0]                   old_slot;
	logic [AW-1:0]                   slot_nxt;
	logic                            accept;
	logic                            out_load;
	logic                            win_full;
	logic [SB-1:0]                   ram_rdata;
	logic signed [SB-1:0]            old_mux;
	logic [SB-1:0]                   abs_new;
	logic [SB-1:0]                   abs_old;
	logic [ROOT_W-1:0]               abs_sum;
	logic                            sqn_busy;
	logic                            sqo_busy;
	logic [2*SB-1:0]                 sqn_p;
	logic [2*SB-1:0]                 sqo_p;
	logic                            ws_busy;
	logic                            ss_busy;
	logic [NUM_W-1:0]                ws_p;
	logic [NUM_W-1:0]                ss_p;
	logic [NUM_W-1:0]                diff;
	logic                            root_busy;
	logic [ROOT_W-1:0]               root;
	logic                            div_busy;
	logic [ROOT_W-1:0]               div_q;
	logic [rwsd_pkg::VOL_W-1:0]      vol_clamped;
	logic                            sq_start;
	logic                            mul_start;
	logic                            root_start;
	logic                            div_start;

	// zero means one, anything past the ring saturates
	always_comb begin
		if (win_len_q == '0) begin
			w = CW'(1);
		end else if (32'(win_len_q) > MAX_WINDOW) begin
			w = CW'(MAX_WINDOW);
		end else begin
			w = CW'(win_len_q);
		end
	end

	// oldest sample sits w slots behind the write slot
	assign slot_dif = DIF_W'(slot_q) - DIF_W'(w);
	assign old_slot = slot_dif[DIF_W-1] ? AW'(slot_dif + DIF_W'(MAX_WINDOW)) : AW'(slot_dif);
	assign slot_nxt = (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;

	assign accept   = feed.valid && feed.ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);
	assign win_full = (filled_q >= w);

	assign old_mux  = evict_q ? $signed(ram_rdata) : '0;
	assign abs_new  = sample_q[SB-1] ? SB'(-sample_q) : SB'(sample_q);
	assign abs_old  = old_mux[SB-1] ? SB'(-old_mux) : SB'(old_mux);
	assign abs_sum  = sum_q[SUM_W-1] ? ROOT_W'(-sum_q) : ROOT_W'(sum_q);
	assign diff     = (ws_p >= ss_p) ? ws_p - ss_p : '0;

	assign vol_clamped = (64'(div_q) > 64'(rwsd_pkg::VOL_MAX)) ? rwsd_pkg::VOL_MAX
		: rwsd_pkg::VOL_W'(div_q);

	assign sq_start   = (state_q == S_LOAD);
	assign mul_start  = (state_q == S_ACC) && win_full;
	assign root_start = (state_q == S_MUL) && !ws_busy && !ss_busy;
	assign div_start  = (state_q == S_ROOT) && !root_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_len_q   <= rwsd_pkg::WINDOW_RESET;
			slot_q      <= '0;
			filled_q    <= '0;
			sum_q       <= '0;
			sq_sum_q    <= '0;
			evict_q     <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (feed.valid) begin
						evict_q <= !feed.restart && win_full;
						if (feed.restart) begin
							slot_q   <= '0;
							filled_q <= '0;
							sum_q    <= '0;
							sq_sum_q <= '0;
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					slot_q <= slot_nxt;
					if (!win_full) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (!sqn_busy && !sqo_busy) begin
						sum_q    <= sum_q - SUM_W'(old_q) + SUM_W'(sample_q);
						sq_sum_q <= sq_sum_q - SQ_W'(sqo_p) + SQ_W'(sqn_p);
						state_q  <= S_ACC;
					end
				end
				S_ACC: begin
					full_q  <= win_full;
					state_q <= win_full ? S_MUL : S_DONE;
				end
				S_MUL: begin
					if (!ws_busy && !ss_busy) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (!root_busy) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a window length write drops the history like a restart
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
				slot_q    <= '0;
				filled_q  <= '0;
				sum_q     <= '0;
				sq_sum_q  <= '0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= feed.sample;
		end
		if (state_q == S_LOAD) begin
			old_q <= old_mux;
		end
		if (out_load) begin
			vol_q   <= full_q ? vol_clamped : '0;
			wfull_q <= full_q;
		end
	end

	rwsd_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_LOAD),
		.waddr (slot_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (old_slot),
		.rdata (ram_rdata)
	);

	rwsd_mul #(
		.A_W (SB),
		.B_W (SB)
	) u_sq_new (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.a      (abs_new),
		.b      (abs_new),
		.busy   (sqn_busy),
		.p      (sqn_p)
	);

	rwsd_mul #(
		.A_W (SB),
		.B_W (SB)
	) u_sq_old (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.a      (abs_old),
		.b      (abs_old),
		.busy   (sqo_busy),
		.p      (sqo_p)
	);

	// w * sum of squares, iterating over the window length bits
	rwsd_mul #(
		.A_W (SQ_W),
		.B_W (CW)
	) u_mul_ws (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sq_sum_q),
		.b      (w),
		.busy   (ws_busy),
		.p      (ws_p)
	);

	rwsd_mul #(
		.A_W (ROOT_W),
		.B_W (ROOT_W)
	) u_mul_ss (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (abs_sum),
		.b      (abs_sum),
		.busy   (ss_busy),
		.p      (ss_p)
	);

	rwsd_sqrt #(
		.R_W (ROOT_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.x      (diff),
		.busy   (root_busy),
		.root   (root)
	);

	rwsd_div #(
		.N_W (ROOT_W),
		.D_W (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (root),
		.d      (w),
		.busy   (div_busy),
		.q      (div_q)
	);

	assign feed.ready         = (state_q == S_IDLE);
	assign result.valid       = out_valid_q;
	assign result.volatility  = vol_q;
	assign result.window_full = wfull_q;

endmodule

@@ rtl/rwsd_chk.sv @@
// port level checks for the rolling window deviation block, bound to the top
`timescale 1ns / 1ps

module rwsd_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [rwsd_pkg::VOL_W-1:0]  volatility,
	input  logic                        window_full
);

	// one beat at a time: the feed closes right after a beat is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("feed still ready after a beat was taken");

	// the serial datapath keeps a result from showing right after a feed beat is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after a feed beat");

	a_short_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_full |-> volatility == '0)
		else $error("nonzero deviation on a short window");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(volatility) && $stable(window_full))
		else $error("stalled result beat changed");

endmodule

bind rolling_window_std_deviation rwsd_chk u_rwsd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (feed.valid),
	.in_ready    (feed.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.volatility  (result.volatility),
	.window_full (result.window_full)
);
